// ----- hdl/swmm_pkg.sv -----
// Shared types and constants for the windowed min, max and mean statistics block.
package swmm_pkg;

	localparam int LEVEL_W = 20;
	localparam int TIME_W  = 32;
	localparam int MEAN_W  = 28;
	localparam int HELD_W  = 5;
	localparam int FRAC_W  = 8;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic [1:0] MODE_RECORD = 2'd0;
	localparam logic [1:0] MODE_QUERY  = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd1;

	localparam logic [TIME_W-1:0]  INTERVAL_RESET  = 32'd5000;
	localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 20'd1000;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_EXEC   = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_DIV    = 5'b01000,
		ST_FINISH = 5'b10000
	} swmm_state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic scan_step;
		logic div_step;
		logic finish;
	} swmm_cmd_t;

	typedef struct packed {
		logic is_query;
		logic empty;
		logic scan_done;
		logic div_done;
		logic out_free;
	} swmm_stat_t;

endpackage

// ----- hdl/swmm_ctrl.sv -----
// FSM taking one request through execute, scan and divide (non-empty query) and finish.
module swmm_ctrl
	import swmm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  swmm_stat_t stat,
	output swmm_cmd_t  cmd
);

	swmm_state_t state_q;
	swmm_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.is_query && !stat.empty) begin
					state_nxt = ST_SCAN;
				end else begin
					state_nxt = ST_FINISH;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_done) begin
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				if (stat.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hdl/swmm_dp.sv -----
// Datapath with configuration, sample ring, scan accumulators, serial divider and output register.
module swmm_dp
	import swmm_pkg::*;
#(
	parameter int WINDOW_DEPTH = 16
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic [1:0]           mode,
	input  logic [TIME_W-1:0]    now_ms,
	input  logic [LEVEL_W-1:0]   free_level,
	input  swmm_cmd_t            cmd,
	output swmm_stat_t           stat,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 stored,
	output logic [LEVEL_W-1:0]   min_level,
	output logic [LEVEL_W-1:0]   max_level,
	output logic [MEAN_W-1:0]    mean_level_q8,
	output logic [HELD_W-1:0]    entries_held,
	output logic                 low_flag
);

	localparam int CW   = $clog2(WINDOW_DEPTH + 1);
	localparam int AW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int SUMW = LEVEL_W + CW;
	localparam int DIVW = SUMW + FRAC_W;
	localparam int DCW  = $clog2(DIVW + 1);

	logic [TIME_W-1:0]  interval_q;
	logic [LEVEL_W-1:0] thresh_q;

	logic [1:0]         mode_q;
	logic [TIME_W-1:0]  now_q;
	logic [LEVEL_W-1:0] level_q;
	logic               low_q;
	logic               stored_q;

	logic [AW-1:0]      slot_q;
	logic [CW-1:0]      count_q;
	logic [TIME_W-1:0]  last_q;

	logic [LEVEL_W-1:0] store_mem [WINDOW_DEPTH];
	logic [LEVEL_W-1:0] rd_data_s1;
	logic               rd_pend_s1;
	logic [CW-1:0]      rd_idx_q;
	logic               first_q;

	logic [LEVEL_W-1:0] min_q;
	logic [LEVEL_W-1:0] max_q;
	logic [SUMW-1:0]    sum_q;
	logic [DIVW-1:0]    quo_q;
	logic [CW-1:0]      rem_q;
	logic [DCW-1:0]     div_cnt_q;

	logic               out_valid_q;
	logic               out_stored_q;
	logic [LEVEL_W-1:0] out_min_q;
	logic [LEVEL_W-1:0] out_max_q;
	logic [MEAN_W-1:0]  out_mean_q;
	logic [HELD_W-1:0]  out_held_q;
	logic               out_low_q;

	logic [TIME_W-1:0]  elapsed;
	logic               rec_hit;
	logic               mem_we;
	logic               mem_re;
	logic               last_datum;
	logic [SUMW-1:0]    sum_nxt;
	logic [CW:0]        trial;
	logic [CW:0]        diff;
	logic               qbit;
	logic               out_free;

	assign elapsed    = now_q - last_q;
	assign rec_hit    = (mode_q == MODE_RECORD) && (elapsed >= interval_q);
	assign mem_we     = cmd.exec && rec_hit;
	assign mem_re     = cmd.scan_step && (rd_idx_q < count_q);
	assign last_datum = cmd.scan_step && rd_pend_s1 && (rd_idx_q == count_q);
	assign sum_nxt    = (first_q ? '0 : sum_q) + SUMW'(rd_data_s1);
	assign trial      = {rem_q, quo_q[DIVW-1]};
	assign diff       = trial - {1'b0, count_q};
	assign qbit       = (trial >= {1'b0, count_q});
	assign out_free   = !out_valid_q || !out_stall;

	assign stat.is_query  = (mode_q == MODE_QUERY);
	assign stat.empty     = (count_q == '0);
	assign stat.scan_done = last_datum;
	assign stat.div_done  = cmd.div_step && (div_cnt_q == DCW'(1));
	assign stat.out_free  = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
			thresh_q   <= THRESHOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INTERVAL:  interval_q <= cfg_wdata;
				REG_THRESHOLD: thresh_q   <= cfg_wdata[LEVEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			now_q   <= now_ms;
			level_q <= free_level;
			low_q   <= (free_level < thresh_q);
		end
	end

	// The ring fills from slot zero, so a query never reads a slot that was not written.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[slot_q] <= level_q;
		end
		if (mem_re) begin
			rd_data_s1 <= store_mem[rd_idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q   <= '0;
			count_q  <= '0;
			last_q   <= '0;
			stored_q <= 1'b0;
		end else if (cmd.exec) begin
			stored_q <= rec_hit;
			if (rec_hit) begin
				slot_q <= (slot_q == AW'(WINDOW_DEPTH - 1)) ? '0 : slot_q + AW'(1);
				if (count_q != CW'(WINDOW_DEPTH)) begin
					count_q <= count_q + CW'(1);
				end
				last_q <= now_q;
			end else if (mode_q == MODE_CLEAR) begin
				slot_q  <= '0;
				count_q <= '0;
				last_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q   <= '0;
			rd_pend_s1 <= 1'b0;
			first_q    <= 1'b0;
		end else if (cmd.exec) begin
			rd_idx_q   <= '0;
			rd_pend_s1 <= 1'b0;
			first_q    <= 1'b1;
		end else if (cmd.scan_step) begin
			rd_pend_s1 <= mem_re;
			if (mem_re) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			if (rd_pend_s1) begin
				first_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			min_q <= level_q;
			max_q <= level_q;
			quo_q <= DIVW'({level_q, {FRAC_W{1'b0}}});
		end else if (cmd.scan_step && rd_pend_s1) begin
			sum_q <= sum_nxt;
			if (first_q || (rd_data_s1 < min_q)) begin
				min_q <= rd_data_s1;
			end
			if (first_q || (rd_data_s1 > max_q)) begin
				max_q <= rd_data_s1;
			end
			if (last_datum) begin
				quo_q     <= {sum_nxt, {FRAC_W{1'b0}}};
				rem_q     <= '0;
				div_cnt_q <= DCW'(DIVW);
			end
		end else if (cmd.div_step) begin
			quo_q     <= {quo_q[DIVW-2:0], qbit};
			rem_q     <= qbit ? diff[CW-1:0] : trial[CW-1:0];
			div_cnt_q <= div_cnt_q - DCW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish && out_free) begin
			out_stored_q <= stored_q;
			out_held_q   <= HELD_W'(count_q);
			out_low_q    <= low_q;
			if (mode_q == MODE_QUERY) begin
				out_min_q  <= min_q;
				out_max_q  <= max_q;
				out_mean_q <= quo_q[MEAN_W-1:0];
			end else begin
				out_min_q  <= '0;
				out_max_q  <= '0;
				out_mean_q <= '0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign stored        = out_stored_q;
	assign min_level     = out_min_q;
	assign max_level     = out_max_q;
	assign mean_level_q8 = out_mean_q;
	assign entries_held  = out_held_q;
	assign low_flag      = out_low_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(WINDOW_DEPTH))
		else $error("held count exceeds the window depth");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (count_q != '0))
		else $error("divide started with an empty window");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> (rd_idx_q < CW'(WINDOW_DEPTH)))
		else $error("scan read beyond the window");

	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.finish))
		else $error("result shown without a finish command");

endmodule

// ----- hdl/sample_window_min_max_mean.sv -----
// Top level of the windowed min, max and mean statistics block.
//
// One request enters on the input channel (in_valid, in_stall) and gives exactly one result on
// the output channel (out_valid, out_stall). A record request stores free_level in the ring when
// the wrapped time since the last stored sample reaches the interval; a query returns minimum,
// maximum and mean of the held samples; a clear empties the history.
// Configuration must be written through cfg_we, cfg_index and cfg_wdata while the block is
// idle; the block itself does not enforce this. Record, clear and unused modes pass through
// the execute and finish states before the result register loads, then return to idle for the
// next request. A query of a non-empty ring also passes through a scan state, where the ring
// memory delivers one sample per cycle, and a divide state giving one quotient bit per cycle.
// One request is in flight at a time; a new request is accepted while the previous result waits
// in the output register. When the receiver stalls, the result holds and the block stops after
// the next request is processed. Reset loads the default interval and threshold and empties the
// history; no clearing pass is needed since stale ring entries are never read.
module sample_window_min_max_mean
	import swmm_pkg::*;
#(
	parameter int WINDOW_DEPTH = 16
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           mode,
	input  logic [TIME_W-1:0]    now_ms,
	input  logic [LEVEL_W-1:0]   free_level,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 stored,
	output logic [LEVEL_W-1:0]   min_level,
	output logic [LEVEL_W-1:0]   max_level,
	output logic [MEAN_W-1:0]    mean_level_q8,
	output logic [HELD_W-1:0]    entries_held,
	output logic                 low_flag
);

	swmm_cmd_t  cmd;
	swmm_stat_t stat;
	logic       in_ready;

	assign in_stall = !in_ready;

	swmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	swmm_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.mode          (mode),
		.now_ms        (now_ms),
		.free_level    (free_level),
		.cmd           (cmd),
		.stat          (stat),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.stored        (stored),
		.min_level     (min_level),
		.max_level     (max_level),
		.mean_level_q8 (mean_level_q8),
		.entries_held  (entries_held),
		.low_flag      (low_flag)
	);

endmodule

// ----- tb/swmm_stats_checker.sv -----
// Checker that predicts and compares every result of the windowed min, max and mean block.
module swmm_stats_checker
	import swmm_pkg::*;
#(
	parameter int WINDOW_DEPTH = 16
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [1:0]           mode,
	input  logic [TIME_W-1:0]    now_ms,
	input  logic [LEVEL_W-1:0]   free_level,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 stored,
	input  logic [LEVEL_W-1:0]   min_level,
	input  logic [LEVEL_W-1:0]   max_level,
	input  logic [MEAN_W-1:0]    mean_level_q8,
	input  logic [HELD_W-1:0]    entries_held,
	input  logic                 low_flag,
	output int                   failures,
	output int                   outstanding,
	output int                   results_checked,
	output int                   samples_stored
);

	typedef struct packed {
		logic               stored;
		logic [LEVEL_W-1:0] min_level;
		logic [LEVEL_W-1:0] max_level;
		logic [MEAN_W-1:0]  mean_level_q8;
		logic [HELD_W-1:0]  entries_held;
		logic               low_flag;
	} window_stats_t;

	window_stats_t      expected_stats[$];
	logic [TIME_W-1:0]  interval_ms;
	logic [LEVEL_W-1:0] threshold;
	logic [LEVEL_W-1:0] ring [WINDOW_DEPTH];
	int                 write_pos;
	int                 held;
	logic [TIME_W-1:0]  last_time;

	function automatic void clear_window();
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			ring[i] = '0;
		end
		write_pos = 0;
		held = 0;
		last_time = '0;
	endfunction

	function automatic window_stats_t apply_request(logic [1:0] op, logic [TIME_W-1:0] t,
			logic [LEVEL_W-1:0] lvl);
		window_stats_t     r;
		logic [TIME_W-1:0] elapsed;
		longint unsigned   total;
		int                i;
		r = '0;
		case (op)
			MODE_RECORD: begin
				elapsed = t - last_time;
				if (elapsed >= interval_ms) begin
					ring[write_pos] = lvl;
					write_pos = (write_pos + 1) % WINDOW_DEPTH;
					if (held < WINDOW_DEPTH)
						held++;
					last_time = t;
					r.stored = 1'b1;
				end
			end
			MODE_QUERY: begin
				if (held == 0) begin
					r.min_level = lvl;
					r.max_level = lvl;
					r.mean_level_q8 = {lvl, {FRAC_W{1'b0}}};
				end else begin
					r.min_level = ring[0];
					r.max_level = ring[0];
					total = 0;
					for (i = 0; i < held; i++) begin
						if (ring[i] < r.min_level)
							r.min_level = ring[i];
						if (ring[i] > r.max_level)
							r.max_level = ring[i];
						total += ring[i];
					end
					r.mean_level_q8 = MEAN_W'((total << FRAC_W) / held);
				end
			end
			MODE_CLEAR: begin
				clear_window();
			end
			default: begin
			end
		endcase
		r.entries_held = HELD_W'(held);
		r.low_flag = lvl < threshold;
		return r;
	endfunction

	function automatic int field_miss(string field, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		window_stats_t want;
		int            miss;
		if (!arst_n) begin
			interval_ms = INTERVAL_RESET;
			threshold = THRESHOLD_RESET;
			clear_window();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_stats.size() == 0) begin
					$error("result arrived with no request outstanding");
					failures++;
				end else begin
					want = expected_stats.pop_front();
					miss = field_miss("stored", want.stored, stored)
						+ field_miss("min_level", want.min_level, min_level)
						+ field_miss("max_level", want.max_level, max_level)
						+ field_miss("mean_level_q8", want.mean_level_q8, mean_level_q8)
						+ field_miss("entries_held", want.entries_held, entries_held)
						+ field_miss("low_flag", want.low_flag, low_flag);
					if (miss != 0)
						failures++;
					results_checked++;
					if (want.stored)
						samples_stored++;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_INTERVAL:  interval_ms = cfg_wdata;
					REG_THRESHOLD: threshold = cfg_wdata[LEVEL_W-1:0];
					default: begin
					end
				endcase
			end
			if (in_valid && !in_stall)
				expected_stats.push_back(apply_request(mode, now_ms, free_level));
			outstanding = expected_stats.size();
		end
	end

endmodule

// ----- tb/tb_sample_window_min_max_mean.sv -----
// Testbench top for the windowed min, max and mean block: clock, reset, stimulus and verdict.
module tb_sample_window_min_max_mean
	import swmm_pkg::*;
();

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int SEGMENTS      = 8;
	localparam int SEGMENT_ITEMS = 200;
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 80;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           mode;
	logic [TIME_W-1:0]    now_ms;
	logic [LEVEL_W-1:0]   free_level;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 stored;
	logic [LEVEL_W-1:0]   min_level;
	logic [LEVEL_W-1:0]   max_level;
	logic [MEAN_W-1:0]    mean_level_q8;
	logic [HELD_W-1:0]    entries_held;
	logic                 low_flag;
	int                   failures;
	int                   outstanding;
	int                   results_checked;
	int                   samples_stored;

	int                   send_idle_pct = 0;
	int                   stall_pct = 0;
	int                   hold_asks = 0;
	int                   hold_seen = 0;
	int                   hold_left = 0;
	int                   quiet_cycles = 0;
	int                   sent_by_mode [4];
	int                   settings_used = 1;
	logic [TIME_W-1:0]    clock_ms = '0;
	logic [TIME_W-1:0]    interval_now = INTERVAL_RESET;
	logic [LEVEL_W-1:0]   threshold_now = THRESHOLD_RESET;

	sample_window_min_max_mean DUT (.*);

	swmm_stats_checker stats_check (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(negedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else begin
			out_stall = $urandom_range(99) < stall_pct;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout: no request or result accepted for %0d cycles.", QUIET_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_request(logic [1:0] op, logic [TIME_W-1:0] t, logic [LEVEL_W-1:0] lvl);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		mode = op;
		now_ms = t;
		free_level = lvl;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_by_mode[op]++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		wait_drained();
		repeat (8) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_INTERVAL)
			interval_now = data;
		else
			threshold_now = data[LEVEL_W-1:0];
	endtask

	task automatic random_request();
		int                 pick;
		logic [1:0]         op;
		logic [TIME_W-1:0]  t;
		logic [LEVEL_W-1:0] lvl;
		pick = $urandom_range(99);
		if (pick < 62)
			op = MODE_RECORD;
		else if (pick < 94)
			op = MODE_QUERY;
		else if (pick < 97)
			op = MODE_CLEAR;
		else
			op = MODE_SPARE;
		if (op == MODE_RECORD) begin
			if ($urandom_range(9) == 0)
				clock_ms = $urandom();
			else
				clock_ms = clock_ms + interval_now + $urandom_range(0, 4) - 2;
			t = clock_ms;
		end else begin
			t = $urandom_range(1) ? clock_ms : $urandom();
		end
		case ($urandom_range(7))
			0: lvl = '0;
			1: lvl = '1;
			2: lvl = LEVEL_W'(threshold_now + $urandom_range(0, 2) - 1);
			default: lvl = LEVEL_W'($urandom());
		endcase
		send_request(op, t, lvl);
	endtask

	initial begin
		int s;
		int k;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_INTERVAL;
		cfg_wdata = '0;
		in_valid = 1'b0;
		mode = MODE_RECORD;
		now_ms = '0;
		free_level = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset defaults: empty-ring queries, interval boundary, wrapped time.
		send_request(MODE_QUERY, '0, '0);
		send_request(MODE_QUERY, '1, '1);
		send_request(MODE_RECORD, 32'd0, 20'd5);
		send_request(MODE_RECORD, 32'd5000, 20'd999);
		send_request(MODE_RECORD, 32'd9999, 20'd1000);
		send_request(MODE_SPARE, 32'h1234_5678, 20'd1001);
		send_request(MODE_QUERY, 32'd10000, 20'd7);
		send_request(MODE_CLEAR, 32'd20000, 20'd0);
		send_request(MODE_QUERY, 32'd20000, 20'h80000);
		send_request(MODE_RECORD, 32'hFFFF_FFFF, 20'hFFFFF);
		send_request(MODE_RECORD, 32'd4999, 20'd1);

		// With a zero interval every record stores, so the ring saturates and wraps.
		write_register(REG_INTERVAL, '0);
		settings_used++;
		for (k = 0; k < 15; k++)
			send_request(MODE_RECORD, 32'd4999, (k % 2 != 0) ? '1 : '0);
		send_request(MODE_QUERY, '0, 20'd3);

		for (s = 0; s < SEGMENTS; s++) begin
			case (s % 4)
				0: begin
					write_register(REG_INTERVAL, '0);
					write_register(REG_THRESHOLD, $urandom() & 32'hFFF0_0000);
				end
				1: begin
					write_register(REG_INTERVAL, 32'hFFFF_FFFF);
					write_register(REG_THRESHOLD, $urandom() | 32'h000F_FFFF);
				end
				2: begin
					write_register(REG_INTERVAL, $urandom_range(1, 20000));
					write_register(REG_THRESHOLD, $urandom());
				end
				default: begin
					write_register(REG_INTERVAL, INTERVAL_RESET);
					write_register(REG_THRESHOLD, THRESHOLD_RESET);
				end
			endcase
			settings_used++;
			case ((s / 2) % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 74;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 74;
				end
				default: begin
					send_idle_pct = 7;
					stall_pct = 7;
				end
			endcase
			for (k = 0; k < SEGMENT_ITEMS; k++) begin
				if (s == 0 && k == 60)
					hold_asks++;
				if (s == 1 && k == 100)
					wait_drained();
				random_request();
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display(
			"Sent %0d record, %0d query, %0d clear and %0d unused requests; %0d settings.",
			sent_by_mode[MODE_RECORD], sent_by_mode[MODE_QUERY], sent_by_mode[MODE_CLEAR],
			sent_by_mode[MODE_SPARE], settings_used);
		$display("Checked %0d results, %0d of which stored a sample; %0d failed.",
			results_checked, samples_stored, failures);
		if (failures == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
